// File: rtl/utf8_stream_decoder_unit_assert.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
// Expects clk_i and rst_ni in the scope of each use.
// Define ASSERT_OFF to compile all checks away.
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define UTF8D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("utf8d check failed");
// Consequent must hold in the cycle after the antecedent.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8d check failed");
`else
`define UTF8D_ASSERT(lbl, prop)
`define UTF8D_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/utf8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; imported by every decoder module.
package utf8d_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [CpW-1:0] ReplReset = 21'h002592;
  localparam logic [CpW-1:0] Min2Byte  = 21'h000080;
  localparam logic [CpW-1:0] Min3Byte  = 21'h000800;
  localparam logic [CpW-1:0] Min4Byte  = 21'h010000;
  localparam logic [CpW-1:0] MaxCode   = 21'h10FFFF;

  // Work passed from the decode front to the output back.
  typedef enum logic [1:0] {
    CMD_VALUE,       // emit value as a decoded code point
    CMD_REPL,        // emit the replacement code
    CMD_REPL_ASCII   // emit the replacement code, then value as ASCII
  } cmd_e;

  typedef struct packed {
    cmd_e           kind;
    logic [CpW-1:0] value;
  } q_entry_t;

endpackage

// File: rtl/utf8d_front.sv
// Decode front: accepts bytes, tracks the multibyte sequence state and
// queues output commands. Depends on utf8d_pkg and the assertion header.
`include "utf8_stream_decoder_unit_assert.svh"

module utf8d_front import utf8d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  logic           in_seq_q, in_seq_d;
  logic [2:0]     total_q, total_d;
  logic [2:0]     seen_q, seen_d;
  logic [CpW-1:0] partial_q, partial_d;

  logic           accept;
  logic [CpW-1:0] shifted;
  logic [2:0]     seen_inc;
  logic           bad;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign shifted    = {partial_q[CpW-7:0], in_byte_i[5:0]};
  assign seen_inc   = seen_q + 3'd1;

  always_comb begin
    bad = ((total_q == 3'd2) && (shifted < Min2Byte)) ||
          ((total_q == 3'd3) && (shifted < Min3Byte)) ||
          ((total_q == 3'd4) && ((shifted < Min4Byte) || (shifted > MaxCode)));
  end

  always_comb begin
    in_seq_d  = in_seq_q;
    total_d   = total_q;
    seen_d    = seen_q;
    partial_d = partial_q;
    q_push_o  = 1'b0;
    q_entry_o = '{kind: CMD_VALUE, value: {{(CpW-8){1'b0}}, in_byte_i}};
    if (accept) begin
      if (!in_byte_i[7]) begin
        q_push_o = 1'b1;
        if (in_seq_q) begin
          q_entry_o.kind = CMD_REPL_ASCII;
          in_seq_d  = 1'b0;
          total_d   = 3'd0;
          seen_d    = 3'd0;
          partial_d = '0;
        end
      end else if (in_byte_i[7:6] == 2'b10) begin
        if (!in_seq_q) begin
          q_push_o       = 1'b1;
          q_entry_o.kind = CMD_REPL;
        end else if (seen_inc == total_q) begin
          // Sequence complete: range check, then back to idle.
          q_push_o        = 1'b1;
          q_entry_o.kind  = bad ? CMD_REPL : CMD_VALUE;
          q_entry_o.value = shifted;
          in_seq_d  = 1'b0;
          total_d   = 3'd0;
          seen_d    = 3'd0;
          partial_d = '0;
        end else begin
          partial_d = shifted;
          seen_d    = seen_inc;
        end
      end else if (in_byte_i[7:5] == 3'b110) begin
        in_seq_d  = 1'b1;
        total_d   = 3'd2;
        seen_d    = 3'd1;
        partial_d = {{(CpW-5){1'b0}}, in_byte_i[4:0]};
      end else if (in_byte_i[7:4] == 4'b1110) begin
        in_seq_d  = 1'b1;
        total_d   = 3'd3;
        seen_d    = 3'd1;
        partial_d = {{(CpW-4){1'b0}}, in_byte_i[3:0]};
      end else if (in_byte_i[7:3] == 5'b11110) begin
        in_seq_d  = 1'b1;
        total_d   = 3'd4;
        seen_d    = 3'd1;
        partial_d = {{(CpW-3){1'b0}}, in_byte_i[2:0]};
      end else begin
        q_push_o       = 1'b1;
        q_entry_o.kind = CMD_REPL;
        in_seq_d  = 1'b0;
        total_d   = 3'd0;
        seen_d    = 3'd0;
        partial_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q  <= 1'b0;
      total_q   <= 3'd0;
      seen_q    <= 3'd0;
      partial_q <= '0;
    end else begin
      in_seq_q  <= in_seq_d;
      total_q   <= total_d;
      seen_q    <= seen_d;
      partial_q <= partial_d;
    end
  end

  // Inside a sequence the byte count stays between the lead and the last byte.
  `UTF8D_ASSERT(a_seq_count_ok, !in_seq_q || ((seen_q >= 3'd1) && (seen_q < total_q) && (total_q >= 3'd2) && (total_q <= 3'd4)))

endmodule

// File: rtl/utf8d_queue.sv
// Small command queue between the decode front and the output back.
// Depends on utf8d_pkg and the assertion header.
`include "utf8_stream_decoder_unit_assert.svh"

module utf8d_queue import utf8d_pkg::*; #(
  parameter int unsigned QDepth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  q_entry_t        slots_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(QDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `UTF8D_ASSERT(a_no_push_full, !(push_i && full_o))
  `UTF8D_ASSERT(a_no_pop_empty, !(pop_i && empty_o))

endmodule

// File: rtl/utf8d_back.sv
// Output back: expands queued commands into result transfers and holds
// the replacement code register. Depends on utf8d_pkg and the assertion header.
`include "utf8_stream_decoder_unit_assert.svh"

module utf8d_back import utf8d_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [CpW-1:0] cfg_wdata_i,
  input  q_entry_t       head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           replaced_o,
  output logic           last_of_run_o
);

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_e;

  phase_e         phase_q, phase_d;
  logic           out_valid_q, out_valid_d;
  logic [CpW-1:0] cp_q, cp_d;
  logic           repl_flag_q, repl_flag_d;
  logic           last_q, last_d;
  logic [CpW-1:0] repl_code_q;
  logic           load;

  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cp_d        = cp_q;
    repl_flag_d = repl_flag_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (load && !empty_i) begin
      out_valid_d = 1'b1;
      case (head_i.kind)
        CMD_REPL: begin
          cp_d        = repl_code_q;
          repl_flag_d = 1'b1;
          last_d      = 1'b1;
          pop_o       = 1'b1;
        end
        CMD_REPL_ASCII: begin
          if (phase_q == PH_FIRST) begin
            cp_d        = repl_code_q;
            repl_flag_d = 1'b1;
            last_d      = 1'b0;
            phase_d     = PH_SECOND;
          end else begin
            cp_d        = head_i.value;
            repl_flag_d = 1'b0;
            last_d      = 1'b1;
            phase_d     = PH_FIRST;
            pop_o       = 1'b1;
          end
        end
        default: begin
          cp_d        = head_i.value;
          repl_flag_d = 1'b0;
          last_d      = 1'b1;
          pop_o       = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
      cp_q        <= '0;
      repl_flag_q <= 1'b0;
      last_q      <= 1'b0;
      repl_code_q <= ReplReset;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      cp_q        <= cp_d;
      repl_flag_q <= repl_flag_d;
      last_q      <= last_d;
      if (cfg_we_i) begin
        repl_code_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = cp_q;
  assign replaced_o    = repl_flag_q;
  assign last_of_run_o = last_q;

  // The second half of a split command keeps its entry at the queue head.
  `UTF8D_ASSERT(a_phase_has_entry, (phase_q == PH_FIRST) || !empty_i)
  `UTF8D_ASSERT_NEXT(a_first_half_not_last, load && !empty_i && (head_i.kind == CMD_REPL_ASCII) && (phase_q == PH_FIRST), out_valid_q && !last_q && repl_flag_q)

endmodule

// File: rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.

// The decoder takes one byte per transfer on the input channel and gives
// decoded code points on the output channel, one result per transfer. The
// input accepts a byte in every cycle while the command queue has room; the
// output gives one result in every cycle while the consumer is ready. Most
// bytes cause zero or one result. An ASCII byte that breaks off an open
// sequence causes two results (the replacement code, then the ASCII byte),
// and these occupy the output register one after the other, so the
// sustained input rate equals the output rate, one byte per cycle, except
// for those bytes, which each cost an extra output transfer. The front
// decode stage updates the sequence state and pushes a command into a queue
// of QueueDepth entries; the back stage turns each command into results in
// its output register once the command has passed through the queue. When
// the queue is full the input stalls; lead bytes and middle continuation
// bytes need no queue room in principle, but are held as well. The
// replacement code register is written through cfg_we_i and cfg_wdata_i and
// resets to U+2592; the user must write it only while the decoder is idle,
// which the block itself does not enforce.

module utf8_stream_decoder_unit import utf8d_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [CpW-1:0] cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           replaced_o,
  output logic           last_of_run_o
);

  // Command queue plumbing between front and back.
  logic     q_push;
  q_entry_t q_push_entry;
  logic     q_pop;
  q_entry_t q_head;
  logic     q_full;
  logic     q_empty;

  // Front: classify each byte and advance the sequence state.
  utf8d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_push_entry)
  );

  // Queue: lets the input keep flowing while results wait downstream.
  utf8d_queue #(
    .QDepth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  // Back: expand commands into result transfers.
  utf8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
